FILE: rtl/dapc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dual converter ping-pong capture block.
// No dependencies.
package dapc_pkg;

	localparam int FRAME_BYTES = 9;
	localparam int NUM_SLOTS   = 4;
	localparam int MEM_DEPTH   = NUM_SLOTS * FRAME_BYTES;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int CNT_W       = 4;

	// input function codes
	localparam logic [1:0] FUNC_READY = 2'd0;
	localparam logic [1:0] FUNC_BYTE  = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// full-bank codes
	localparam logic [1:0] FULL_NONE  = 2'd0;
	localparam logic [1:0] FULL_BANK0 = 2'd1;
	localparam logic [1:0] FULL_BANK1 = 2'd2;

	// chip select codes
	localparam logic [1:0] SEL_NONE   = 2'd0;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_START   = 3'd1,
		KIND_NEXT    = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_BYTE    = 3'd4,
		KIND_NOFRAME = 3'd5
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic item_load;
		logic exec_fire;
		logic rd_start;
		logic rd_emit;
		logic second_emit;
	} dapc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;
		logic read_hit;
		logic chain_start;
		logic rd_last;
	} dapc_sts_t;

endpackage

FILE: rtl/dapc_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the capture block.
// Depends on dapc_pkg.
module dapc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dapc_pkg::dapc_sts_t sts,
	output dapc_pkg::dapc_cmd_t cmd
);
	import dapc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SECOND = 5'b00100,
		ST_READ   = 5'b01000,
		ST_SPARE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// a read of a full bank goes to the memory first
				if (sts.read_hit) begin
					cmd.rd_start = 1'b1;
					state_d = ST_READ;
				end else if (sts.out_free) begin
					cmd.exec_fire = 1'b1;
					if (sts.chain_start)
						state_d = ST_SECOND;
					else
						state_d = ST_IDLE;
				end
			end
			ST_SECOND: begin
				if (sts.out_free) begin
					cmd.second_emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (sts.out_free) begin
					cmd.rd_emit = 1'b1;
					if (sts.rd_last)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/dapc_datapath.sv
`timescale 1ns / 1ps
// Capture state, frame memory and result register of the capture block.
// Depends on dapc_pkg.
module dapc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dapc_pkg::dapc_cmd_t cmd,
	output dapc_pkg::dapc_sts_t sts,
	input  logic [1:0]          func,
	input  logic                source_chip,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          kind,
	output logic                result_chip,
	output logic                bank,
	output logic [1:0]          cs_state,
	output logic [7:0]          data_byte,
	output logic                last
);
	import dapc_pkg::*;

	// item register
	logic [1:0] func_q;
	logic       chip_q;
	logic [7:0] rx_q;

	// capture state
	logic             pend_q [2];
	logic [1:0]       full_q [2];
	logic             capt_q;
	logic             act_chip_q;
	logic             act_bank_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       sel_q;

	logic             pend_d [2];
	logic [1:0]       full_d [2];
	logic             capt_d;
	logic             act_chip_d;
	logic             act_bank_d;
	logic [CNT_W-1:0] cnt_d;
	logic [1:0]       sel_d;

	// first result of an executed word
	kind_t      r_kind;
	logic       r_chip;
	logic       r_bank;
	logic [1:0] r_cs;
	logic       r_last;
	logic       chain;
	logic       mem_we;
	logic       other;

	// frame memory and read side
	logic [7:0]        mem [MEM_DEPTH];
	logic [7:0]        rd_data_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  rd_idx_d;
	logic              rd_bank_q;
	logic              rd_bank_d;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              read_hit;

	// output register
	logic       out_valid_q;
	logic       out_load;
	kind_t      o_kind;
	logic       o_chip;
	logic       o_bank;
	logic [1:0] o_cs;
	logic [7:0] o_data;
	logic       o_last;
	logic [2:0] kind_q;
	logic       chip_o_q;
	logic       bank_q;
	logic [1:0] cs_q;
	logic [7:0] data_q;
	logic       last_q;

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			func_q <= func;
			chip_q <= source_chip;
			rx_q   <= rx_byte;
		end
	end

	assign read_hit = (func_q == FUNC_READ) &&
		((full_q[chip_q] == FULL_BANK0) || (full_q[chip_q] == FULL_BANK1));
	assign other    = ~act_chip_q;
	assign wr_addr  = ADDR_W'({act_chip_q, act_bank_q}) * ADDR_W'(FRAME_BYTES)
		+ ADDR_W'(cnt_q);

	always_comb begin
		pend_d     = pend_q;
		full_d     = full_q;
		capt_d     = capt_q;
		act_chip_d = act_chip_q;
		act_bank_d = act_bank_q;
		cnt_d      = cnt_q;
		sel_d      = sel_q;
		r_kind     = KIND_NONE;
		r_chip     = chip_q;
		r_bank     = 1'b0;
		r_cs       = sel_q;
		r_last     = 1'b1;
		chain      = 1'b0;
		mem_we     = 1'b0;
		unique case (func_q)
			FUNC_READY: begin
				if (pend_q[~chip_q]) begin
					pend_d[chip_q] = 1'b1;
				end else if (!pend_q[chip_q]) begin
					pend_d[chip_q] = 1'b1;
					capt_d         = 1'b1;
					act_chip_d     = chip_q;
					act_bank_d     = (full_q[chip_q] == FULL_BANK0);
					cnt_d          = '0;
					sel_d          = {chip_q, ~chip_q};
					r_kind         = KIND_START;
					r_bank         = (full_q[chip_q] == FULL_BANK0);
					r_cs           = {chip_q, ~chip_q};
				end
			end
			FUNC_BYTE: begin
				if (capt_q) begin
					mem_we = 1'b1;
					r_chip = act_chip_q;
					r_bank = act_bank_q;
					if (32'(cnt_q) + 32'd1 >= 32'(FRAME_BYTES)) begin
						capt_d             = 1'b0;
						cnt_d              = '0;
						pend_d[act_chip_q] = 1'b0;
						full_d[act_chip_q] = {act_bank_q, ~act_bank_q};
						r_kind             = KIND_DONE;
						// start the waiting chip on the freed link
						if (pend_q[other]) begin
							chain      = 1'b1;
							r_last     = 1'b0;
							pend_d[other] = 1'b1;
							capt_d     = 1'b1;
							act_chip_d = other;
							act_bank_d = (full_q[other] == FULL_BANK0);
							sel_d      = {other, ~other};
						end
					end else begin
						cnt_d  = cnt_q + CNT_W'(1);
						r_kind = KIND_NEXT;
					end
				end
			end
			FUNC_READ: begin
				if (!read_hit)
					r_kind = KIND_NOFRAME;
			end
			default: begin
				r_kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q[0]  <= 1'b0;
			pend_q[1]  <= 1'b0;
			full_q[0]  <= FULL_NONE;
			full_q[1]  <= FULL_NONE;
			capt_q     <= 1'b0;
			act_chip_q <= 1'b0;
			act_bank_q <= 1'b0;
			cnt_q      <= '0;
			sel_q      <= SEL_NONE;
		end else if (cmd.exec_fire) begin
			pend_q     <= pend_d;
			full_q     <= full_d;
			capt_q     <= capt_d;
			act_chip_q <= act_chip_d;
			act_bank_q <= act_bank_d;
			cnt_q      <= cnt_d;
			sel_q      <= sel_d;
		end
	end

	// read side: fetch the next byte while the current one is presented
	assign rd_bank_d = cmd.rd_start ? (full_q[chip_q] == FULL_BANK1) : rd_bank_q;
	assign rd_idx_d  = cmd.rd_start ? '0 : rd_idx_q + CNT_W'(1);
	assign sts.rd_last = (32'(rd_idx_q) == FRAME_BYTES - 1);
	assign rd_en     = cmd.rd_start || (cmd.rd_emit && !sts.rd_last);
	assign rd_addr   = ADDR_W'({chip_q, rd_bank_d}) * ADDR_W'(FRAME_BYTES)
		+ ADDR_W'(rd_idx_d);

	always_ff @(posedge clk) begin
		if (cmd.exec_fire && mem_we)
			mem[wr_addr] <= rx_q;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_bank_q <= 1'b0;
		end else if (rd_en) begin
			rd_idx_q  <= rd_idx_d;
			rd_bank_q <= rd_bank_d;
		end
	end

	// result select
	always_comb begin
		o_kind = KIND_NONE;
		o_chip = chip_q;
		o_bank = 1'b0;
		o_cs   = sel_q;
		o_data = '0;
		o_last = 1'b1;
		priority if (cmd.exec_fire) begin
			o_kind = r_kind;
			o_chip = r_chip;
			o_bank = r_bank;
			o_cs   = r_cs;
			o_last = r_last;
		end else if (cmd.second_emit) begin
			o_kind = KIND_START;
			o_chip = act_chip_q;
			o_bank = act_bank_q;
		end else if (cmd.rd_emit) begin
			o_kind = KIND_BYTE;
			o_bank = rd_bank_q;
			o_data = rd_data_q;
			o_last = sts.rd_last;
		end else begin
			// nothing to load: keep the defaults
			o_kind = KIND_NONE;
		end
	end

	assign out_load = cmd.exec_fire || cmd.second_emit || cmd.rd_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= o_kind;
			chip_o_q <= o_chip;
			bank_q   <= o_bank;
			cs_q     <= o_cs;
			data_q   <= o_data;
			last_q   <= o_last;
		end
	end

	assign sts.out_free    = !out_valid_q || out_ready;
	assign sts.read_hit    = read_hit;
	assign sts.chain_start = chain;

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign result_chip = chip_o_q;
	assign bank        = bank_q;
	assign cs_state    = cs_q;
	assign data_byte   = data_q;
	assign last        = last_q;

endmodule

FILE: rtl/dual_adc_pingpong_capture_top.sv
`timescale 1ns / 1ps
// Top level of the dual converter ping-pong capture block.
// Depends on dapc_pkg, dapc_ctrl and dapc_datapath.
//
// Two converters share one serial link; each owns two frame banks of nine
// bytes. The input channel (in_valid/in_ready) carries one word per event:
// func selects data-ready, received byte or frame read, source_chip names
// the converter, rx_byte carries the byte. The output channel
// (out_valid/out_ready) returns one or more result words per input word;
// last marks the final one.
//
// A data-ready or byte word is held in the item register and, once the output
// register is free, executed into it; a frame completion that starts the
// waiting chip adds one more word from the second-result state. A frame read
// fetches from the single read port of the frame memory first, so its nine
// bytes follow from the read data register, one per cycle while the receiver
// does not stall. An input word is taken again once the last result is loaded.
//
// Reset clears all capture and chip select state; the frame memory keeps
// its contents and only banks marked full are ever read.
// A stalled receiver holds the result register; the block waits, and takes
// the next input word while the final result of a word is still pending.
module dual_adc_pingpong_capture_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic       source_chip,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic       result_chip,
	output logic       bank,
	output logic [1:0] cs_state,
	output logic [7:0] data_byte,
	output logic       last
);
	import dapc_pkg::*;

	dapc_cmd_t cmd;
	dapc_sts_t sts;

	// sequencing: accept, execute, stream frame bytes
	dapc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// capture state, frame memory and result register
	dapc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.source_chip (source_chip),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.result_chip (result_chip),
		.bank        (bank),
		.cs_state    (cs_state),
		.data_byte   (data_byte),
		.last        (last)
	);

endmodule
